// ----- rtl/bba_pkg.sv -----
// Package for the block bitmap allocator: command and result transaction types,
// action, status and register codes, and default sizing constants.
// No dependencies.
package bba_pkg;

    localparam int BBA_MAX_BLOCKS = 32768;
    localparam int BBA_WORD_BITS  = 32;

    // Configuration port sizing.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_TOTAL_BLOCKS    = 1'b0;
    localparam logic REG_RESERVED_BLOCKS = 1'b1;

    // Action codes.
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_FORMAT = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [14:0] blk_idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] granted_block;
        logic [15:0] free_count;
    } t_result;

endpackage

// ----- rtl/block_bitmap_allocator.sv -----
// First-fit block allocator over a usage bitmap held in one word-wide RAM.
// Depends on bba_pkg and bba_ram.
//
// A command is taken when start is high and busy is low; its single result appears
// on o_result for exactly one cycle with o_done high and cannot be held off.
// Timing is set by the single read port of the map RAM, one word per cycle:
// an allocate scans map words starting at the lowest word that may still hold a
// clear bit; a failed allocate found without scanning, an out-of-range free and the
// unused action code are answered straight from idle; a free reads the word and
// writes it back; a format rewrites every map word. After reset, busy stays high
// while the map is cleared; the APB registers can be written during that time.
// WORD_BITS must be a power of two.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS,
    parameter int WORD_BITS  = bba_pkg::BBA_WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bba_pkg::t_cmd               i_cmd,
    output logic                        o_done,
    output bba_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bba_pkg::CFG_AW-1:0]  paddr,
    input  logic [bba_pkg::CFG_DW-1:0]  pwdata,
    output logic [bba_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    import bba_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WB_LG     = $clog2(WORD_BITS);
    // Block index width: holds MAX_BLOCKS itself and any 16-bit total.
    localparam int IW        = ($clog2(MAX_BLOCKS) + 1 > 17) ? $clog2(MAX_BLOCKS) + 1 : 17;
    localparam int WCW       = IW - WB_LG;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_FREE = 2'd3;

    // Bits of the word starting at block base that lie below block lim.
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [IW-1:0] lim,
                                                      input logic [IW-1:0] base);
        logic [IW-1:0]        rem;
        logic [WORD_BITS-1:0] m;
        rem = lim - base;
        m   = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            m[b] = (lim > base) && (rem > IW'(b));
        end
        return m;
    endfunction

    logic [1:0]           r_state, n_state;
    logic [WCW-1:0]       r_w, n_w;
    logic [WCW-1:0]       r_hint, n_hint;
    logic [WB_LG-1:0]     r_pos, n_pos;
    logic [IW-1:0]        r_res, n_res;
    logic                 r_fmt, n_fmt;
    logic [15:0]          r_cnt, n_cnt;
    logic [15:0]          r_total, r_reserved;
    logic                 r_done, n_done;
    t_result              r_result, n_result;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [IW-1:0]        eff_total, res_clamp, idx_ext, base, sum_words;
    logic [WCW-1:0]       nwords, idx_word, w_inc;
    logic [WORD_BITS-1:0] clr_bits;
    logic [WB_LG-1:0]     found_pos;
    logic [IW-1:0]        granted;
    logic                 cfg_wr;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESERVED_BLOCKS) ? {16'd0, r_reserved} : {16'd0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= 16'd20480;
            r_reserved <= 16'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TOTAL_BLOCKS) begin
                r_total <= pwdata[15:0];
            end else begin
                r_reserved <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        eff_total = (IW'(r_total) > IW'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(r_total);
        res_clamp = (IW'(r_reserved) > eff_total) ? eff_total : IW'(r_reserved);
        sum_words = eff_total + IW'(WORD_BITS - 1);
        nwords    = sum_words[IW-1:WB_LG];
        idx_ext   = IW'(i_cmd.blk_idx);
        idx_word  = idx_ext[IW-1:WB_LG];
        base      = {r_w, {WB_LG{1'b0}}};
        w_inc     = r_w + WCW'(1);
        clr_bits  = ~ram_rdata & low_mask(eff_total, base);
        found_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (clr_bits[b]) begin
                found_pos = WB_LG'(b);
            end
        end
        granted   = {r_w, found_pos};
    end

    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_hint    = r_hint;
        n_pos     = r_pos;
        n_res     = r_res;
        n_fmt     = r_fmt;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_w[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_hint[AW-1:0];

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = low_mask(r_res, base);
                if (r_w == WCW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                    if (r_fmt) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_DONE, granted_block: 15'd0, free_count: r_cnt};
                    end
                end else begin
                    n_w = w_inc;
                end
            end
            S_IDLE: begin
                // The first map read goes out in the same cycle the command is taken.
                ram_raddr = (i_cmd.action == ACT_FREE) ? idx_word[AW-1:0] : r_hint[AW-1:0];
                if (start) begin
                    unique case (i_cmd.action)
                        ACT_ALLOC: begin
                            if (r_hint >= nwords) begin
                                n_done   = 1'b1;
                                n_result = '{status: ST_NOFREE, granted_block: 15'd0,
                                             free_count: r_cnt};
                            end else begin
                                n_w     = r_hint;
                                n_state = S_CHK;
                            end
                        end
                        ACT_FREE: begin
                            if (idx_ext >= eff_total) begin
                                n_done   = 1'b1;
                                n_result = '{status: ST_RANGE, granted_block: 15'd0,
                                             free_count: r_cnt};
                            end else begin
                                n_w     = idx_word;
                                n_pos   = idx_ext[WB_LG-1:0];
                                n_state = S_FREE;
                            end
                        end
                        ACT_FORMAT: begin
                            n_res   = res_clamp;
                            n_cnt   = 16'(eff_total - res_clamp);
                            n_hint  = res_clamp[IW-1:WB_LG];
                            n_w     = '0;
                            n_fmt   = 1'b1;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_DONE, granted_block: 15'd0,
                                         free_count: r_cnt};
                        end
                    endcase
                end
            end
            S_CHK: begin
                // Fetch the next word speculatively so the scan runs a word per cycle.
                ram_raddr = w_inc[AW-1:0];
                if (|clr_bits) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (WORD_BITS'(1) << found_pos);
                    n_cnt     = (r_cnt != 16'd0) ? r_cnt - 16'd1 : r_cnt;
                    n_done    = 1'b1;
                    n_result  = '{status: ST_DONE, granted_block: granted[14:0],
                                  free_count: n_cnt};
                    n_state   = S_IDLE;
                end else begin
                    // Words below the hint are known to be completely used.
                    if ((&ram_rdata) && (r_w == r_hint)) begin
                        n_hint = w_inc;
                    end
                    if (w_inc < nwords) begin
                        n_w = w_inc;
                    end else begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_NOFREE, granted_block: 15'd0,
                                     free_count: r_cnt};
                        n_state  = S_IDLE;
                    end
                end
            end
            S_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_pos);
                n_cnt     = (r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;
                n_hint    = (r_w < r_hint) ? r_w : r_hint;
                n_done    = 1'b1;
                n_result  = '{status: ST_DONE, granted_block: 15'd0, free_count: n_cnt};
                n_state   = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_w     <= '0;
            r_hint  <= '0;
            r_res   <= '0;
            r_fmt   <= 1'b0;
            r_cnt   <= 16'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_hint  <= n_hint;
            r_res   <= n_res;
            r_fmt   <= n_fmt;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    // Every accepted command is either still in progress or answered next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command neither in progress nor answered");

    // The map is never written while the block waits for a command.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("map written while idle");

    // Only a successful allocate reports a nonzero block.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_DONE)) |-> (o_result.granted_block == 15'd0))
        else $error("granted block set on a failed command");

    // A found clear bit ends the scan, with the result shown in the cycle after.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHK) && (|clr_bits)) |=> (o_done && (r_state == S_IDLE)))
        else $error("allocation hit did not produce a result");
`endif

endmodule

// ----- rtl/bba_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used for the allocator's usage map.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/tb_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for block_bitmap_allocator: directed and random commands
// are checked against a bit-level predictor of the usage map and free counter.
// Depends on bba_pkg and the allocator RTL.
module tb_block_bitmap_allocator;
    import bba_pkg::*;

    localparam int MAP_BLOCKS = BBA_MAX_BLOCKS;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_AW-1:0] ADDR_TOTAL    = CFG_AW'(int'(REG_TOTAL_BLOCKS) * 4);
    localparam logic [CFG_AW-1:0] ADDR_RESERVED = CFG_AW'(int'(REG_RESERVED_BLOCKS) * 4);

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_done;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // Predicted state of the allocator.
    bit   [MAP_BLOCKS-1:0] used_blocks;
    logic [15:0]           pred_free;
    logic [15:0]           cfg_total;
    logic [15:0]           cfg_reserved;

    t_result pending_results[$];
    t_result oldest_result;
    bit      idle_on = 1'b1;
    int      mismatch_count = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_granted = 0;
    int      n_nofree = 0;
    int      n_range = 0;
    int      n_formats = 0;

    block_bitmap_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int effective_total();
        return (int'(cfg_total) > MAP_BLOCKS) ? MAP_BLOCKS : int'(cfg_total);
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] action, input logic [14:0] index);
        t_cmd c;
        c.action  = action;
        c.blk_idx = index;
        return c;
    endfunction

    // Applies one command to the predicted map and counter and returns its result.
    function automatic t_result allocation_outcome(input t_cmd c);
        t_result r;
        int      lim;
        int      res;
        bit      found;
        r     = '0;
        lim   = effective_total();
        found = 1'b0;
        case (c.action)
            ACT_ALLOC: begin
                r.status = ST_NOFREE;
                for (int i = 0; i < lim && !found; i++) begin
                    if (!used_blocks[i]) begin
                        used_blocks[i] = 1'b1;
                        if (pred_free != 16'd0) pred_free--;
                        r.status        = ST_DONE;
                        r.granted_block = 15'(i);
                        found           = 1'b1;
                    end
                end
            end
            ACT_FREE: begin
                if (int'(c.blk_idx) >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    used_blocks[c.blk_idx] = 1'b0;
                    if (pred_free != 16'hFFFF) pred_free++;
                end
            end
            ACT_FORMAT: begin
                res         = (int'(cfg_reserved) > lim) ? lim : int'(cfg_reserved);
                used_blocks = '0;
                for (int i = 0; i < res; i++) used_blocks[i] = 1'b1;
                pred_free = 16'(lim - res);
            end
            default: begin
            end
        endcase
        r.free_count = pred_free;
        return r;
    endfunction

    // Holds start high until the command is taken. With no idle gap drawn, start
    // stays high so that the next call issues back to back.
    task automatic send_cmd(input t_cmd c);
        t_result r;
        int      gap;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        r = allocation_outcome(c);
        pending_results.push_back(r);
        n_sent++;
        if (c.action == ACT_ALLOC && r.status == ST_DONE) n_granted++;
        if (r.status == ST_NOFREE) n_nofree++;
        if (r.status == ST_RANGE) n_range++;
        if (c.action == ACT_FORMAT) n_formats++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both registers back to back, then reads them back.
    task automatic cfg_set(input logic [15:0] total, input logic [15:0] reserved);
        logic [CFG_AW-1:0] addr [4];
        logic [15:0]       val [4];
        addr = '{ADDR_TOTAL, ADDR_RESERVED, ADDR_TOTAL, ADDR_RESERVED};
        val  = '{total, reserved, total, reserved};
        for (int k = 0; k < 4; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (k < 2);
            paddr   <= addr[k];
            pwdata  <= CFG_DW'(val[k]);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (k >= 2 && prdata[15:0] !== val[k]) begin
                $display("%0t: register readback at 0x%0h: expected %0d actual %0d",
                         $time, addr[k], val[k], prdata[15:0]);
                mismatch_count++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_total    = total;
        cfg_reserved = reserved;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                n_checked++;
                if (o_result.status !== oldest_result.status) begin
                    $display("%0t: status: expected %0d actual %0d",
                             $time, oldest_result.status, o_result.status);
                    mismatch_count++;
                end
                if (o_result.granted_block !== oldest_result.granted_block) begin
                    $display("%0t: granted_block: expected %0d actual %0d",
                             $time, oldest_result.granted_block, o_result.granted_block);
                    mismatch_count++;
                end
                if (o_result.free_count !== oldest_result.free_count) begin
                    $display("%0t: free_count: expected %0d actual %0d",
                             $time, oldest_result.free_count, o_result.free_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset leaves the counter at zero over a clear map, so the first allocate
    // succeeds without moving the counter.
    task automatic test_after_reset();
        send_cmd(make_cmd(ACT_ALLOC, 15'h7FFF));
        send_cmd(make_cmd(ACT_FREE, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'd20480));
        send_cmd(make_cmd(ACT_FREE, 15'h7FFF));
        send_cmd(make_cmd(ACT_UNUSED, 15'h5555));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        wait_drained();
    endtask

    task automatic test_exhaust_small_map();
        cfg_set(16'd8, 16'd3);
        send_cmd(make_cmd(ACT_FORMAT, 15'h2AAA));
        repeat (6) send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'd7));
        send_cmd(make_cmd(ACT_FREE, 15'd8));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        wait_drained();
    endtask

    task automatic test_zero_total();
        cfg_set(16'd0, 16'd0);
        send_cmd(make_cmd(ACT_FORMAT, 15'd0));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'd0));
        wait_drained();
    endtask

    task automatic test_reserved_clamp();
        cfg_set(16'd4, 16'd10);
        send_cmd(make_cmd(ACT_FORMAT, 15'd0));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'd3));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        wait_drained();
    endtask

    // A total above the map size acts as the full map.
    task automatic test_oversize_total();
        cfg_set(16'hFFFF, 16'd32768);
        send_cmd(make_cmd(ACT_FORMAT, 15'd0));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        send_cmd(make_cmd(ACT_FREE, 15'h7FFF));
        send_cmd(make_cmd(ACT_ALLOC, 15'd0));
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [15:0] totals [8];
        logic [15:0] reserves [8];
        int          lim;
        int          pick;
        t_cmd        c;
        totals   = '{16'd1, 16'd1, 16'd40, 16'd64, 16'd33, 16'd200, 16'd20480, 16'hFFFF};
        reserves = '{16'd0, 16'hFFFF, 16'd5, 16'd0, 16'd31, 16'd199, 16'd4095, 16'd32768};
        for (int p = 0; p < 8; p++) begin
            // The closing phases draw no idle gaps, so start stays high while they send commands.
            if (p >= 6) idle_on = 1'b0;
            cfg_set(totals[p], reserves[p]);
            send_cmd(make_cmd(ACT_FORMAT, 15'($urandom)));
            for (int k = 0; k < 80; k++) begin
                lim  = effective_total();
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    c = make_cmd(ACT_ALLOC, 15'($urandom));
                end else if (pick < 80) begin
                    c = make_cmd(ACT_FREE,
                                 (lim > 0) ? 15'($urandom_range(0, lim - 1)) : 15'($urandom));
                end else if (pick < 92) begin
                    c = make_cmd(ACT_FREE, 15'($urandom));
                end else if (pick < 96) begin
                    c = make_cmd(ACT_FORMAT, 15'($urandom));
                end else begin
                    c = make_cmd(ACT_UNUSED, 15'($urandom));
                end
                send_cmd(c);
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        used_blocks  = '0;
        pred_free    = 16'd0;
        cfg_total    = 16'd20480;
        cfg_reserved = 16'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_exhaust_small_map();
        test_zero_total();
        test_reserved_clamp();
        test_oversize_total();
        test_random_phases();

        // Run on after the last result so that any unexpected further result is caught.
        repeat (1100) @(posedge i_clk);
        $display("Sent %0d commands: %0d grants, %0d no-free, %0d out-of-range, %0d formats.",
                 n_sent, n_granted, n_nofree, n_range, n_formats);
        $display("Checked %0d results against the predicted map and counter.", n_checked);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("block_bitmap_allocator test passed");
        end else begin
            $display("block_bitmap_allocator test failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("block_bitmap_allocator test failed");
        $finish;
    end

endmodule
